### sv/assert_macros.svh
// Assertion helpers used by the timer queue top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tq_pkg.sv
package tq_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_EXPIRE = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  localparam logic [62:0] TIME_MAX = {63{1'b1}};
  localparam int MAX_RESULTS = 16;

  // Sequencer phases
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_EMIT,
    S_FINAL
  } state_t;

  // Command from the sequencer to every cell
  typedef struct packed {
    logic        add_wr;    // write the free slot chosen during scan
    logic        cancel;    // clear the addressed slot if sequence matches
    logic        expire;    // fire the cell selected as minimum expired
    logic [62:0] now;
    logic [62:0] wr_expiry;
    logic [31:0] wr_interval;
    logic [31:0] wr_seq;
    logic [31:0] cancel_seq;
  } cell_cmd_t;

endpackage

### sv/tq_cell.sv
module tq_cell
  import tq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  logic        sel_add,     // this cell is the chosen free slot
  input  logic        sel_cancel,  // this cell is the cancel target
  input  logic        sel_fire,    // this cell is the picked expired timer
  output logic        valid,
  output logic [62:0] expiry,
  output logic [31:0] seq,
  output logic        due          // valid and expiry at or before now
);

  logic        valid_r;
  logic [62:0] expiry_r;
  logic [31:0] interval_r;
  logic [31:0] seq_r;
  logic [63:0] reload;

  assign reload = {1'b0, cmd.now} + {32'd0, interval_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.add_wr && sel_add) begin
      valid_r <= 1'b1;
    end else if (cmd.cancel && sel_cancel && valid_r && seq_r == cmd.cancel_seq) begin
      valid_r <= 1'b0;
    end else if (cmd.expire && sel_fire && interval_r == 32'd0) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr && sel_add) begin
      expiry_r   <= cmd.wr_expiry;
      interval_r <= cmd.wr_interval;
      seq_r      <= cmd.wr_seq;
    end else if (cmd.expire && sel_fire) begin
      expiry_r <= reload[63] ? TIME_MAX : reload[62:0];
    end
  end

  assign valid  = valid_r;
  assign expiry = expiry_r;
  assign seq    = seq_r;
  assign due    = valid_r && (expiry_r <= cmd.now);

endmodule

### sv/timer_queue_with_periodic_reload_top.sv
// Timer queue with periodic reload.
// Input: a command transaction is taken at a rising edge with start high and
// busy low. in_func picks add, cancel or expire; the other in_ fields carry
// its operands.
// Output: each result sits on the out_ ports for one cycle with out_valid high;
// out_last marks the final result of a command. The receiver cannot stall.
// Add and cancel give one result, expire one per fired timer (up to 16, in
// expiry then slot order) or a single "none expired" result.
// Timing: a pass reads the slot chain one cell per cycle and ends in an apply
// state. Add, cancel and an unknown func take two passes (the second finds the
// earliest pending expiry after the change); the final pass is followed by
// S_FINAL and then S_EMIT, where the result goes out.
// Expire takes one pass per fired timer, one more that finds none left, and a
// final pass: n+2 passes for 0 <= n < 16 fired timers, 17 when 16 fire. After
// S_FINAL the results go out back to back, one per cycle.
// Reset: all slots free, sequence counter zero, busy low right after reset.
module timer_queue_with_periodic_reload_top
  import tq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [62:0] in_expiry_time,
  input  logic [31:0] in_repeat_interval,
  input  logic [3:0]  in_handle_slot,
  input  logic [31:0] in_handle_seq,
  input  logic [62:0] in_current_time,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [31:0] out_seq,
  output logic        out_earliest_changed,
  output logic [62:0] out_next_expiry,
  output logic        out_armed,
  output logic        out_last
);
  `include "assert_macros.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int QW = $clog2(MAX_RESULTS + 1);

  state_t state_r, state_nxt;

  // Captured command
  logic [1:0]  func_r;
  logic [62:0] exp_in_r;
  logic [31:0] int_in_r;
  logic [3:0]  hslot_r;
  logic [31:0] hseq_r;
  logic [62:0] now_r;
  logic [31:0] seqcnt_r;

  // Scan pointer and accumulators
  logic [CW-1:0] idx_r;
  logic          any_r;     // some valid slot seen
  logic [62:0]   min_r;     // minimum valid expiry
  logic          free_r;
  logic [IW-1:0] free_idx_r;
  logic          pick_r;    // some due, not yet reported slot
  logic [62:0]   pmin_r;
  logic [IW-1:0] pidx_r;
  logic [SLOTS-1:0] taken_r;
  logic          final_pass_r;

  // Result queue for expire
  logic [3:0]  q_slot_r [MAX_RESULTS];
  logic [31:0] q_seq_r  [MAX_RESULTS];
  logic [QW-1:0] q_cnt_r;
  logic [QW-1:0] q_rd_r;

  // Single-result fields and the earliest pending expiry after the command
  logic          hit_r, chg_r;
  logic          add_ok_r;
  logic [IW-1:0] add_slot_r;
  logic [31:0]   add_seq_r;
  logic          any_post_r;
  logic [62:0]   min_post_r;
  logic [IW-1:0] hidx;

  // Cell chain
  cell_cmd_t        cmd;
  logic [SLOTS-1:0] c_valid, c_due;
  logic [62:0]      c_exp [SLOTS];
  logic [31:0]      c_seq [SLOTS];
  logic [SLOTS-1:0] sel_add, sel_cancel, sel_fire;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      assign sel_add[g]    = (free_idx_r == IW'(g));
      assign sel_cancel[g] = ({28'd0, hslot_r} == 32'(g));
      assign sel_fire[g]   = (pidx_r == IW'(g));
      tq_cell u_cell (
        .clk, .rst_n, .cmd,
        .sel_add(sel_add[g]), .sel_cancel(sel_cancel[g]), .sel_fire(sel_fire[g]),
        .valid(c_valid[g]), .expiry(c_exp[g]), .seq(c_seq[g]), .due(c_due[g])
      );
    end
  endgenerate

  logic [IW-1:0] ci;
  logic          scan_done;
  assign ci        = idx_r[IW-1:0];
  assign scan_done = (idx_r == CW'(SLOTS - 1));
  assign hidx      = IW'(hslot_r);

  // Cell commands; writes happen only in the apply state of a pass before the final one
  always_comb begin
    cmd             = '0;
    cmd.add_wr      = (state_r == S_APPLY) && (func_r == FUNC_ADD) && free_r
                      && !final_pass_r;
    cmd.cancel      = (state_r == S_APPLY) && (func_r == FUNC_CANCEL) && !final_pass_r;
    cmd.expire      = (state_r == S_APPLY) && (func_r == FUNC_EXPIRE) && pick_r
                      && !final_pass_r;
    cmd.now         = now_r;
    cmd.wr_expiry   = exp_in_r;
    cmd.wr_interval = int_in_r;
    cmd.wr_seq      = seqcnt_r;
    cmd.cancel_seq  = hseq_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_SCAN;
      S_SCAN:  if (scan_done) state_nxt = S_APPLY;
      S_APPLY: begin
        if (!final_pass_r) state_nxt = S_SCAN;
        else state_nxt = S_FINAL;
      end
      S_FINAL: state_nxt = S_EMIT;
      S_EMIT: begin
        if (func_r != FUNC_EXPIRE || q_cnt_r == '0 ||
            q_rd_r == q_cnt_r - QW'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      seqcnt_r <= '0;
      q_cnt_r  <= '0;
      q_rd_r   <= '0;
      final_pass_r <= 1'b0;
      taken_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r <= in_func; exp_in_r <= in_expiry_time;
            int_in_r <= in_repeat_interval; hslot_r <= in_handle_slot;
            hseq_r <= in_handle_seq; now_r <= in_current_time;
            q_cnt_r <= '0; q_rd_r <= '0; taken_r <= '0;
            final_pass_r <= 1'b0;
          end
          idx_r <= '0; any_r <= 1'b0; free_r <= 1'b0; pick_r <= 1'b0;
        end
        S_SCAN: begin
          // one cell per cycle: earliest, lowest free, minimum due
          if (c_valid[ci] && (!any_r || c_exp[ci] < min_r)) begin
            min_r <= c_exp[ci]; any_r <= 1'b1;
          end
          if (!c_valid[ci] && !free_r) begin
            free_r <= 1'b1; free_idx_r <= ci;
          end
          if (c_due[ci] && !taken_r[ci] && (!pick_r || c_exp[ci] < pmin_r)) begin
            pick_r <= 1'b1; pmin_r <= c_exp[ci]; pidx_r <= ci;
          end
          idx_r <= scan_done ? idx_r : idx_r + CW'(1);
        end
        S_APPLY: begin
          if (cmd.add_wr) seqcnt_r <= seqcnt_r + 32'd1;
          if (cmd.expire) begin
            taken_r[pidx_r] <= 1'b1;
            q_slot_r[q_cnt_r[3:0]] <= 4'(pidx_r);
            q_seq_r[q_cnt_r[3:0]]  <= c_seq[pidx_r];
            q_cnt_r <= q_cnt_r + QW'(1);
            if (q_cnt_r == QW'(MAX_RESULTS - 1)) final_pass_r <= 1'b1;
          end else begin
            // next pass only gathers the earliest pending expiry
            final_pass_r <= 1'b1;
          end
          // cancel hit and earliest change use the state before the write
          if (!final_pass_r) begin
            hit_r <= c_valid[hidx] && ({28'd0, hslot_r} < 32'(SLOTS))
                     && c_seq[hidx] == hseq_r;
            chg_r <= !any_r || exp_in_r < min_r;
          end
          idx_r <= '0; any_r <= 1'b0; pick_r <= 1'b0;
        end
        S_FINAL: begin
          // earliest pending expiry is already in any_post_r/min_post_r
        end
        S_EMIT: begin
          q_rd_r <= q_rd_r + QW'(1);
        end
        default: ;
      endcase
    end
  end

  // Earliest pending after the command, from the last cell of the final pass
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && scan_done && final_pass_r) begin
      any_post_r <= any_r || c_valid[ci];
      min_post_r <= (c_valid[ci] && (!any_r || c_exp[ci] < min_r)) ? c_exp[ci] : min_r;
    end
  end

  // Earliest pending expiry after the command
  logic        rs_any;
  logic [62:0] rs_min;
  assign rs_any = any_post_r;
  assign rs_min = min_post_r;

  assign busy = (state_r != S_IDLE);

  // Output drive
  always_comb begin
    out_valid = (state_r == S_EMIT);
    out_status = ST_NOT_FOUND; out_slot = '0; out_seq = '0;
    out_earliest_changed = 1'b0; out_last = 1'b1;
    out_armed = rs_any; out_next_expiry = rs_any ? rs_min : 63'd0;
    unique case (func_r)
      FUNC_ADD: begin
        if (add_ok_r) begin
          out_status = ST_ADDED; out_slot = 4'(add_slot_r); out_seq = add_seq_r;
          out_earliest_changed = chg_r;
        end else out_status = ST_FULL;
      end
      FUNC_CANCEL: out_status = hit_r ? ST_CANCELLED : ST_NOT_FOUND;
      FUNC_EXPIRE: begin
        if (q_cnt_r == '0) out_status = ST_NONE;
        else begin
          out_status = ST_EXPIRED; out_slot = q_slot_r[q_rd_r[3:0]];
          out_seq = q_seq_r[q_rd_r[3:0]];
          out_last = (q_rd_r == q_cnt_r - QW'(1));
        end
      end
      default: out_status = ST_NOT_FOUND;
    endcase
  end

  // Add result, taken at the end of the first pass
  always_ff @(posedge clk) begin
    if (state_r == S_APPLY && !final_pass_r) begin
      add_ok_r   <= free_r;
      add_slot_r <= free_idx_r;
      add_seq_r  <= seqcnt_r;
    end
  end

  `ASSERT_IMP(a_emit_busy, clk, rst_n, out_valid, busy, "result while idle")
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "command not taken")
  `ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, q_cnt_r <= QW'(MAX_RESULTS), "queue overflow")

endmodule
